// ----- rtl/core/bsp_pkg.sv -----
// shared widths, constants and payload types of the billboard sprite projector
package bsp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int SIZE_MAX  = 32767;

   localparam int CSR_AW  = 5;
   localparam int SCR_W   = 13;
   localparam int POS_W   = 32;
   localparam int FAC_W   = 18;
   localparam int DIFF_W  = POS_W + 1;
   localparam int PROD_W  = DIFF_W + FAC_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int P_W     = SUM_W - FRAC_BITS;
   localparam int SQ_W    = FRAC_BITS + 1;
   localparam int S_W     = FRAC_BITS + 2;
   localparam int HQ_W    = $clog2(SIZE_MAX + 1);
   localparam int HN_W    = SCR_W + FRAC_BITS;
   localparam int WN_W    = HQ_W + 16;
   localparam int WS_W    = FRAC_BITS + 17;
   localparam int NUM_W   = FRAC_BITS + 18;
   localparam int X_W     = NUM_W - FRAC_BITS - 1;
   localparam int DST_W   = 18;
   localparam int DEPTH_W = 31;

   localparam longint ONE   = longint'(1) << FRAC_BITS;
   localparam longint S_LIM = 3 * (longint'(1) << (FRAC_BITS - 1));
   localparam longint RND   = (longint'(1) << (FRAC_BITS + 1)) - 1;

   localparam logic [SCR_W-1:0] RST_SCREEN_W = 13'd320;
   localparam logic [SCR_W-1:0] RST_SCREEN_H = 13'd240;
   localparam logic [FAC_W-1:0] RST_FACING_X = 18'd65536;

   typedef enum logic [2:0] {
      REG_SCREEN_W,
      REG_SCREEN_H,
      REG_CAM_X,
      REG_CAM_Y,
      REG_FACING_X,
      REG_FACING_Y
   } reg_idx_type;

   typedef struct packed {
      logic [15:0] ox;
      logic [15:0] oy;
      logic [15:0] tw;
      logic [15:0] th;
      logic [15:0] mat;
   } tex_type;

   typedef struct packed {
      logic           keep;
      logic           csign;
      logic [P_W-1:0] p;
      tex_type        tex;
   } sdiv_pay_type;

   typedef struct packed {
      logic                  keep;
      logic signed [S_W-1:0] s;
      logic [P_W-1:0]        p;
      tex_type               tex;
   } hdiv_pay_type;

   typedef struct packed {
      logic                   keep;
      logic [HQ_W-1:0]        h;
      logic signed [WS_W-1:0] ws;
      logic [P_W-1:0]         p;
      tex_type                tex;
   } wdiv_pay_type;

endpackage

// ----- rtl/core/bsp_req_if.sv -----
// sprite input channel
interface bsp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sprite_pos_x;
   logic [31:0] sprite_pos_y;
   logic [15:0] tex_org_x;
   logic [15:0] tex_org_y;
   logic [15:0] tex_size_w;
   logic [15:0] tex_size_h;
   logic [15:0] material_id;

   modport source (output valid, sprite_pos_x, sprite_pos_y, tex_org_x, tex_org_y,
                   tex_size_w, tex_size_h, material_id, input ready);
   modport sink (input valid, sprite_pos_x, sprite_pos_y, tex_org_x, tex_org_y,
                 tex_size_w, tex_size_h, material_id, output ready);
endinterface

// ----- rtl/core/bsp_rsp_if.sv -----
// draw command output channel
interface bsp_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        src_left;
   logic [15:0]        src_top;
   logic [16:0]        src_right;
   logic [16:0]        src_bottom;
   logic signed [17:0] dst_left;
   logic signed [17:0] dst_top;
   logic signed [17:0] dst_right;
   logic signed [17:0] dst_bottom;
   logic [30:0]        depth;
   logic [15:0]        out_material;

   modport source (output valid, src_left, src_top, src_right, src_bottom, dst_left,
                   dst_top, dst_right, dst_bottom, depth, out_material, input ready);
   modport sink (input valid, src_left, src_top, src_right, src_bottom, dst_left,
                 dst_top, dst_right, dst_bottom, depth, out_material, output ready);
endinterface

// ----- rtl/core/billboard_sprite_projector_unit.sv -----
// throughput: one sprite per cycle while no result is held; the three pipelined dividers set the depth
// a held result stalls every stage together, culled sprites leave no beat
// reset: synchronous, clears all valid bits and loads register defaults
// registers: 320x240 screen, camera at origin, facing +x
module billboard_sprite_projector_unit (
   input  logic                        clock,
   input  logic                        reset,
   bsp_req_if.sink                     req_ch,
   bsp_rsp_if.source                   rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [bsp_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   localparam int F = bsp_pkg::FRAC_BITS;

   // configuration registers
   logic [bsp_pkg::SCR_W-1:0]        screen_w_ff, screen_h_ff;
   logic signed [bsp_pkg::POS_W-1:0] cam_x_ff, cam_y_ff;
   logic signed [bsp_pkg::FAC_W-1:0] fx_ff, fy_ff;
   logic                             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_w_ff <= bsp_pkg::RST_SCREEN_W;
         screen_h_ff <= bsp_pkg::RST_SCREEN_H;
         cam_x_ff    <= '0;
         cam_y_ff    <= '0;
         fx_ff       <= bsp_pkg::RST_FACING_X;
         fy_ff       <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            bsp_pkg::REG_SCREEN_W: screen_w_ff <= csr_pwdata[bsp_pkg::SCR_W-1:0];
            bsp_pkg::REG_SCREEN_H: screen_h_ff <= csr_pwdata[bsp_pkg::SCR_W-1:0];
            bsp_pkg::REG_CAM_X:    cam_x_ff    <= csr_pwdata;
            bsp_pkg::REG_CAM_Y:    cam_y_ff    <= csr_pwdata;
            bsp_pkg::REG_FACING_X: fx_ff       <= csr_pwdata[bsp_pkg::FAC_W-1:0];
            bsp_pkg::REG_FACING_Y: fy_ff       <= csr_pwdata[bsp_pkg::FAC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         bsp_pkg::REG_SCREEN_W: csr_prdata = 32'(screen_w_ff);
         bsp_pkg::REG_SCREEN_H: csr_prdata = 32'(screen_h_ff);
         bsp_pkg::REG_CAM_X:    csr_prdata = cam_x_ff;
         bsp_pkg::REG_CAM_Y:    csr_prdata = cam_y_ff;
         bsp_pkg::REG_FACING_X: csr_prdata = 32'(fx_ff);
         bsp_pkg::REG_FACING_Y: csr_prdata = 32'(fy_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // whole pipeline advances unless a result beat is held
   logic en;
   logic out_v_ff;

   assign en           = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // stage a: accepted beat
   logic                              a_v_ff;
   logic signed [bsp_pkg::POS_W-1:0]  a_px_ff, a_py_ff;
   bsp_pkg::tex_type                  a_tex_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_px_ff  <= req_ch.sprite_pos_x;
         a_py_ff  <= req_ch.sprite_pos_y;
         a_tex_ff <= '{ox: req_ch.tex_org_x, oy: req_ch.tex_org_y, tw: req_ch.tex_size_w,
                       th: req_ch.tex_size_h, mat: req_ch.material_id};
      end
   end

   // stage b: offset from camera
   logic                              b_v_ff;
   logic signed [bsp_pkg::DIFF_W-1:0] b_dx_ff, b_dy_ff;
   bsp_pkg::tex_type                  b_tex_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_dx_ff  <= bsp_pkg::DIFF_W'(a_px_ff) - bsp_pkg::DIFF_W'(cam_x_ff);
         b_dy_ff  <= bsp_pkg::DIFF_W'(a_py_ff) - bsp_pkg::DIFF_W'(cam_y_ff);
         b_tex_ff <= a_tex_ff;
      end
   end

   // stage c: four products
   logic                              c_v_ff;
   logic signed [bsp_pkg::PROD_W-1:0] c_dxfx_ff, c_dyfy_ff, c_dxfy_ff, c_dyfx_ff;
   bsp_pkg::tex_type                  c_tex_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_dxfx_ff <= bsp_pkg::PROD_W'(b_dx_ff) * bsp_pkg::PROD_W'(fx_ff);
         c_dyfy_ff <= bsp_pkg::PROD_W'(b_dy_ff) * bsp_pkg::PROD_W'(fy_ff);
         c_dxfy_ff <= bsp_pkg::PROD_W'(b_dx_ff) * bsp_pkg::PROD_W'(fy_ff);
         c_dyfx_ff <= bsp_pkg::PROD_W'(b_dy_ff) * bsp_pkg::PROD_W'(fx_ff);
         c_tex_ff  <= b_tex_ff;
      end
   end

   // stage d: dot and cross terms
   logic                             d_v_ff;
   logic signed [bsp_pkg::SUM_W-1:0] d_dot_ff, d_cross_ff;
   bsp_pkg::tex_type                 d_tex_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (en) begin
         d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_dot_ff   <= bsp_pkg::SUM_W'(c_dxfx_ff) + bsp_pkg::SUM_W'(c_dyfy_ff);
         d_cross_ff <= bsp_pkg::SUM_W'(c_dxfy_ff) - bsp_pkg::SUM_W'(c_dyfx_ff);
         d_tex_ff   <= c_tex_ff;
      end
   end

   // lateral divide s = |cross| / p
   logic [bsp_pkg::SUM_W-1:0] cross_mag;
   logic [bsp_pkg::P_W-1:0]   p_val;
   bsp_pkg::sdiv_pay_type     s_pay_in, s_pay_out;
   logic                      s_v;
   logic [bsp_pkg::SQ_W-1:0]  s_quot;
   logic                      s_ovf;

   assign cross_mag = d_cross_ff[bsp_pkg::SUM_W-1] ? -d_cross_ff : d_cross_ff;
   assign p_val     = d_dot_ff[bsp_pkg::SUM_W-1:F];
   assign s_pay_in  = '{keep: (d_dot_ff >= $signed(bsp_pkg::SUM_W'(bsp_pkg::ONE))),
                        csign: d_cross_ff[bsp_pkg::SUM_W-1], p: p_val, tex: d_tex_ff};

   bsp_div #(
      .NW(bsp_pkg::SUM_W), .DW(bsp_pkg::P_W), .QW(bsp_pkg::SQ_W),
      .PLW($bits(bsp_pkg::sdiv_pay_type))
   ) u_sdiv (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(d_v_ff), .in_num(cross_mag), .in_den(p_val), .in_pay(s_pay_in),
      .out_valid(s_v), .out_quot(s_quot), .out_ovf(s_ovf), .out_pay(s_pay_out)
   );

   // height divide h = H * one / p
   logic signed [bsp_pkg::S_W-1:0] s_val;
   logic                           s_keep;
   bsp_pkg::hdiv_pay_type          h_pay_in, h_pay_out;
   logic                           h_v;
   logic [bsp_pkg::HQ_W-1:0]       h_quot;
   logic                           h_ovf;

   assign s_val    = s_pay_out.csign ? -bsp_pkg::S_W'(s_quot) : bsp_pkg::S_W'(s_quot);
   assign s_keep   = s_pay_out.keep && !s_ovf
                     && (bsp_pkg::S_W'(s_quot) <= bsp_pkg::S_W'(bsp_pkg::S_LIM))
                     && (s_pay_out.tex.th != 16'd0);
   assign h_pay_in = '{keep: s_keep, s: s_val, p: s_pay_out.p, tex: s_pay_out.tex};

   bsp_div #(
      .NW(bsp_pkg::HN_W), .DW(bsp_pkg::P_W), .QW(bsp_pkg::HQ_W),
      .PLW($bits(bsp_pkg::hdiv_pay_type))
   ) u_hdiv (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s_v), .in_num({screen_h_ff, F'(0)}), .in_den(s_pay_out.p),
      .in_pay(h_pay_in),
      .out_valid(h_v), .out_quot(h_quot), .out_ovf(h_ovf), .out_pay(h_pay_out)
   );

   // stage e: saturate h, width numerator and screen x product
   logic [bsp_pkg::HQ_W-1:0]        h_sat;
   logic signed [bsp_pkg::S_W:0]    s_plus;
   logic                            e_v_ff;
   logic                            e_keep_ff;
   logic [bsp_pkg::HQ_W-1:0]        e_h_ff;
   logic [bsp_pkg::WN_W-1:0]        e_hw_ff;
   logic signed [bsp_pkg::WS_W-1:0] e_ws_ff;
   logic [bsp_pkg::P_W-1:0]         e_p_ff;
   bsp_pkg::tex_type                e_tex_ff;

   assign h_sat  = (h_ovf || (32'(h_quot) > 32'(bsp_pkg::SIZE_MAX)))
                   ? bsp_pkg::HQ_W'(bsp_pkg::SIZE_MAX) : h_quot;
   assign s_plus = (bsp_pkg::S_W+1)'(h_pay_out.s) + (bsp_pkg::S_W+1)'(bsp_pkg::ONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (en) begin
         e_v_ff <= h_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_keep_ff <= h_pay_out.keep;
         e_h_ff    <= h_sat;
         e_hw_ff   <= bsp_pkg::WN_W'(h_sat) * bsp_pkg::WN_W'(h_pay_out.tex.tw);
         e_ws_ff   <= bsp_pkg::WS_W'($signed({1'b0, screen_w_ff})) * bsp_pkg::WS_W'(s_plus);
         e_p_ff    <= h_pay_out.p;
         e_tex_ff  <= h_pay_out.tex;
      end
   end

   // width divide w = h * tw / th
   bsp_pkg::wdiv_pay_type    w_pay_in, w_pay_out;
   logic                     w_v;
   logic [bsp_pkg::HQ_W-1:0] w_quot;
   logic                     w_ovf;

   assign w_pay_in = '{keep: e_keep_ff, h: e_h_ff, ws: e_ws_ff, p: e_p_ff, tex: e_tex_ff};

   bsp_div #(
      .NW(bsp_pkg::WN_W), .DW(16), .QW(bsp_pkg::HQ_W),
      .PLW($bits(bsp_pkg::wdiv_pay_type))
   ) u_wdiv (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(e_v_ff), .in_num(e_hw_ff), .in_den(e_tex_ff.th), .in_pay(w_pay_in),
      .out_valid(w_v), .out_quot(w_quot), .out_ovf(w_ovf), .out_pay(w_pay_out)
   );

   // stage g: saturate w, form the screen x numerator
   logic [bsp_pkg::HQ_W-1:0]         w_sat;
   logic                             g_v_ff;
   logic                             g_keep_ff;
   logic [bsp_pkg::HQ_W-1:0]         g_w_ff, g_h_ff;
   logic signed [bsp_pkg::NUM_W-1:0] g_num_ff;
   logic [bsp_pkg::P_W-1:0]          g_p_ff;
   bsp_pkg::tex_type                 g_tex_ff;

   assign w_sat = (w_ovf || (32'(w_quot) > 32'(bsp_pkg::SIZE_MAX)))
                  ? bsp_pkg::HQ_W'(bsp_pkg::SIZE_MAX) : w_quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (en) begin
         g_v_ff <= w_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_keep_ff <= w_pay_out.keep;
         g_w_ff    <= w_sat;
         g_h_ff    <= w_pay_out.h;
         g_num_ff  <= bsp_pkg::NUM_W'(w_pay_out.ws)
                      - (bsp_pkg::NUM_W'(w_sat >> 1) << (F + 1));
         g_p_ff    <= w_pay_out.p;
         g_tex_ff  <= w_pay_out.tex;
      end
   end

   // output stage: round toward zero, build rectangles
   logic [bsp_pkg::NUM_W-1:0]         num_rnd;
   logic signed [bsp_pkg::X_W-1:0]    x_val;
   logic [bsp_pkg::DST_W-1:0]         x_ext, y_val;
   logic [15:0]                       src_left_ff, src_top_ff, mat_ff;
   logic [16:0]                       src_right_ff, src_bottom_ff;
   logic [bsp_pkg::DST_W-1:0]         dst_left_ff, dst_top_ff, dst_right_ff, dst_bottom_ff;
   logic [bsp_pkg::DEPTH_W-1:0]       depth_ff;

   assign num_rnd = g_num_ff[bsp_pkg::NUM_W-1]
                    ? g_num_ff + bsp_pkg::NUM_W'(bsp_pkg::RND) : g_num_ff;
   assign x_val   = num_rnd[bsp_pkg::NUM_W-1:F+1];
   assign x_ext   = bsp_pkg::DST_W'(x_val);
   assign y_val   = bsp_pkg::DST_W'(screen_h_ff >> 1) - bsp_pkg::DST_W'(g_h_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= g_v_ff && g_keep_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         src_left_ff   <= g_tex_ff.ox;
         src_top_ff    <= g_tex_ff.oy;
         src_right_ff  <= 17'(g_tex_ff.ox) + 17'(g_tex_ff.tw);
         src_bottom_ff <= 17'(g_tex_ff.oy) + 17'(g_tex_ff.th);
         dst_left_ff   <= x_ext;
         dst_top_ff    <= y_val;
         dst_right_ff  <= x_ext + bsp_pkg::DST_W'(g_w_ff);
         dst_bottom_ff <= y_val + bsp_pkg::DST_W'(g_h_ff);
         depth_ff      <= (g_p_ff[bsp_pkg::P_W-1:bsp_pkg::DEPTH_W] != '0)
                          ? '1 : g_p_ff[bsp_pkg::DEPTH_W-1:0];
         mat_ff        <= g_tex_ff.mat;
      end
   end

   assign rsp_ch.valid        = out_v_ff;
   assign rsp_ch.src_left     = src_left_ff;
   assign rsp_ch.src_top      = src_top_ff;
   assign rsp_ch.src_right    = src_right_ff;
   assign rsp_ch.src_bottom   = src_bottom_ff;
   assign rsp_ch.dst_left     = dst_left_ff;
   assign rsp_ch.dst_top      = dst_top_ff;
   assign rsp_ch.dst_right    = dst_right_ff;
   assign rsp_ch.dst_bottom   = dst_bottom_ff;
   assign rsp_ch.depth        = depth_ff;
   assign rsp_ch.out_material = mat_ff;

`ifndef SYNTHESIS
   a_stall_only_on_held: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (rsp_ch.valid && !rsp_ch.ready))
      else $error("input stalled without a held result");

   a_depth_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.depth != '0))
      else $error("result with zero depth");

   a_height_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.dst_bottom - rsp_ch.dst_top) >= 0
                        && (rsp_ch.dst_bottom - rsp_ch.dst_top) <= bsp_pkg::SIZE_MAX))
      else $error("sprite height outside saturation range");
`endif

endmodule

// ----- rtl/core/bsp_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module bsp_div #(
   parameter int NW  = 52,
   parameter int DW  = 36,
   parameter int QW  = 17,
   parameter int PLW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [PLW-1:0] in_pay,
   output logic          out_valid,
   output logic [QW-1:0] out_quot,
   output logic          out_ovf,
   output logic [PLW-1:0] out_pay
);
   localparam int WW = (NW > DW + QW) ? NW : DW + QW;

   logic           v_ff [QW+1];
   logic [WW-1:0]  r_ff [QW+1];
   logic [DW-1:0]  d_ff [QW+1];
   logic [QW-1:0]  q_ff [QW+1];
   logic           o_ff [QW+1];
   logic [PLW-1:0] p_ff [QW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0] <= WW'(in_num);
         d_ff[0] <= in_den;
         q_ff[0] <= '0;
         o_ff[0] <= 1'b0;
         p_ff[0] <= in_pay;
      end
   end

   for (genvar i = 0; i < QW; i++) begin : g_step
      logic [WW-1:0] shifted;
      logic          ge;
      logic          ovf;

      assign shifted = WW'(d_ff[i]) << (QW - 1 - i);
      assign ge      = r_ff[i] >= shifted;
      // quotient wider than QW bits is caught at the first step
      if (i == 0) begin : g_first
         assign ovf = r_ff[0] >= (WW'(d_ff[0]) << QW);
      end else begin : g_rest
         assign ovf = o_ff[i];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[i+1] <= ge ? r_ff[i] - shifted : r_ff[i];
            d_ff[i+1] <= d_ff[i];
            q_ff[i+1] <= q_ff[i] | (QW'(ge) << (QW - 1 - i));
            o_ff[i+1] <= ovf;
            p_ff[i+1] <= p_ff[i];
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign out_quot  = q_ff[QW];
   assign out_ovf   = o_ff[QW];
   assign out_pay   = p_ff[QW];

endmodule

// ----- bench/billboard_sprite_projector_unit_tb.sv -----
// self-checking bench for the billboard sprite projector: directed table, then random sprites
`timescale 1ns / 1ps

module billboard_sprite_projector_unit_tb;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [15:0] org_x;
      logic [15:0] org_y;
      logic [15:0] size_w;
      logic [15:0] size_h;
      logic [15:0] mat;
   } sprite_type;

   typedef struct packed {
      logic [15:0]        src_left;
      logic [15:0]        src_top;
      logic [16:0]        src_right;
      logic [16:0]        src_bottom;
      logic signed [17:0] dst_left;
      logic signed [17:0] dst_top;
      logic signed [17:0] dst_right;
      logic signed [17:0] dst_bottom;
      logic [30:0]        depth;
      logic [15:0]        material;
   } draw_cmd_type;

   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_kind_type;

   typedef struct packed {
      chk_kind_type kind;
      sprite_type   sp;
      draw_cmd_type cmd;
   } dir_row_type;

   localparam int N_DIR     = 13;
   localparam int N_PHASE   = 7;
   localparam int PER_PHASE = 150;
   localparam int LATENCY   = 11 + 2 * bsp_pkg::HQ_W + bsp_pkg::FRAC_BITS;
   localparam logic [bsp_pkg::CSR_AW-1:0] UNMAPPED_ADDR = 5'd24;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [bsp_pkg::CSR_AW-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   bsp_req_if req_ch ();
   bsp_rsp_if rsp_ch ();

   billboard_sprite_projector_unit u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // shadow of the block's registers
   longint scr_w, scr_h, cam_x, cam_y, fac_x, fac_y;

   draw_cmd_type pending_cmds[$];
   dir_row_type  dir_rows[N_DIR];
   int fail_count = 0;
   int sprites_sent = 0;
   int cmds_seen = 0;
   bit valid_high = 0;
   bit send_burst = 0;
   bit recv_burst = 0;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // perspective projection of one sprite; returns 1 when the sprite is drawn
   function automatic bit project_sprite(input sprite_type sp, output draw_cmd_type cmd);
      longint dx, dy, praw, craw, p, s, sa, h, w, num, x, y;
      cmd = '0;
      dx = longint'($signed(sp.pos_x)) - cam_x;
      dy = longint'($signed(sp.pos_y)) - cam_y;
      praw = dx * fac_x + dy * fac_y;
      craw = dx * fac_y - dy * fac_x;
      if (praw < bsp_pkg::ONE) return 0;
      p = praw >>> bsp_pkg::FRAC_BITS;
      s = craw / p;
      sa = (s < 0) ? -s : s;
      if (2 * sa > 3 * bsp_pkg::ONE) return 0;
      if (sp.size_h == 0) return 0;
      h = (scr_h * bsp_pkg::ONE) / p;
      if (h > bsp_pkg::SIZE_MAX) h = bsp_pkg::SIZE_MAX;
      w = (h * longint'(sp.size_w)) / longint'(sp.size_h);
      if (w > bsp_pkg::SIZE_MAX) w = bsp_pkg::SIZE_MAX;
      num = scr_w * (s + bsp_pkg::ONE) - (w / 2) * (2 * bsp_pkg::ONE);
      x = num / (2 * bsp_pkg::ONE);
      y = scr_h / 2 - h / 2;
      cmd.src_left   = sp.org_x;
      cmd.src_top    = sp.org_y;
      cmd.src_right  = 17'(sp.org_x) + 17'(sp.size_w);
      cmd.src_bottom = 17'(sp.org_y) + 17'(sp.size_h);
      cmd.dst_left   = 18'(x);
      cmd.dst_top    = 18'(y);
      cmd.dst_right  = 18'(x + w);
      cmd.dst_bottom = 18'(y + h);
      cmd.depth      = (p > longint'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF : 31'(p);
      cmd.material   = sp.mat;
      return 1;
   endfunction

   function automatic dir_row_type dir_row(chk_kind_type kind, logic [31:0] px,
                                           logic [31:0] py, logic [15:0] ox,
                                           logic [15:0] oy, logic [15:0] tw,
                                           logic [15:0] th, logic [15:0] mat);
      dir_row_type r;
      r.kind = kind;
      r.sp = '{px, py, ox, oy, tw, th, mat};
      r.cmd = '0;
      return r;
   endfunction

   // mostly sprites placed in view of the current camera, the rest noise
   function automatic sprite_type random_sprite();
      sprite_type sp;
      longint pd, lat, sq, dx, dy;
      sp.org_x = 16'($urandom);
      sp.org_y = 16'($urandom);
      sp.mat = 16'($urandom);
      if ($urandom_range(0, 1)) begin
         sp.size_w = 16'($urandom_range(0, 64));
         sp.size_h = 16'($urandom_range(1, 64));
      end else begin
         sp.size_w = 16'($urandom);
         sp.size_h = 16'($urandom);
      end
      if ($urandom_range(0, 19) == 0) sp.size_h = '0;
      if ($urandom_range(0, 4) == 0) begin
         sp.pos_x = $urandom;
         sp.pos_y = $urandom;
      end else begin
         pd = $urandom_range(0, 3) == 0 ? longint'($urandom_range(1, 1 << 16))
                                        : longint'($urandom_range(1 << 12, 1 << 24));
         sq = longint'($urandom_range(0, 6 * (1 << 15))) - 3 * (1 << 15);
         lat = (sq * pd) >>> bsp_pkg::FRAC_BITS;
         dx = (pd * fac_x + lat * fac_y) >>> bsp_pkg::FRAC_BITS;
         dy = (pd * fac_y - lat * fac_x) >>> bsp_pkg::FRAC_BITS;
         sp.pos_x = 32'(cam_x + dx);
         sp.pos_y = 32'(cam_y + dy);
      end
      return sp;
   endfunction

   function automatic int draw_gap(inout bit burst);
      if ($urandom_range(0, 49) == 0) burst = ~burst;
      return burst ? 0 : $urandom_range(0, 8);
   endfunction

   task automatic write_csr(input logic [bsp_pkg::CSR_AW-1:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      unique case (bsp_pkg::reg_idx_type'(addr[4:2]))
         bsp_pkg::REG_SCREEN_W: scr_w = longint'(data[12:0]);
         bsp_pkg::REG_SCREEN_H: scr_h = longint'(data[12:0]);
         bsp_pkg::REG_CAM_X:    cam_x = longint'($signed(data));
         bsp_pkg::REG_CAM_Y:    cam_y = longint'($signed(data));
         bsp_pkg::REG_FACING_X: fac_x = longint'($signed(data[17:0]));
         bsp_pkg::REG_FACING_Y: fac_y = longint'($signed(data[17:0]));
         default: ;
      endcase
   endtask

   task automatic set_view(input logic [31:0] w, input logic [31:0] h, input logic [31:0] cx,
                           input logic [31:0] cy, input logic [31:0] fx, input logic [31:0] fy);
      write_csr(5'(4 * bsp_pkg::REG_SCREEN_W), w);
      write_csr(5'(4 * bsp_pkg::REG_SCREEN_H), h);
      write_csr(5'(4 * bsp_pkg::REG_CAM_X), cx);
      write_csr(5'(4 * bsp_pkg::REG_CAM_Y), cy);
      write_csr(5'(4 * bsp_pkg::REG_FACING_X), fx);
      write_csr(5'(4 * bsp_pkg::REG_FACING_Y), fy);
   endtask

   task automatic send_sprite(input sprite_type sp, input chk_kind_type kind,
                              input draw_cmd_type typed);
      int gap;
      draw_cmd_type cmd;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         if (valid_high) req_ch.valid <= 1'b0;
         valid_high = 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.sprite_pos_x <= sp.pos_x;
      req_ch.sprite_pos_y <= sp.pos_y;
      req_ch.tex_org_x <= sp.org_x;
      req_ch.tex_org_y <= sp.org_y;
      req_ch.tex_size_w <= sp.size_w;
      req_ch.tex_size_h <= sp.size_h;
      req_ch.material_id <= sp.mat;
      valid_high = 1;
      do @(posedge clock); while (!req_ch.ready);
      sprites_sent++;
      unique case (kind)
         CHK_TYPED: pending_cmds.push_back(typed);
         CHK_MODEL: if (project_sprite(sp, cmd)) pending_cmds.push_back(cmd);
         default: ;
      endcase
   endtask

   // let the pipeline empty, culled sprites included, before touching registers
   task automatic drain();
      if (valid_high) req_ch.valid <= 1'b0;
      valid_high = 0;
      wait (pending_cmds.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // result side: random stalls plus one long hold-off to back the pipe up
   initial begin
      int k;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         k = (cmds_seen == 40) ? 400 : draw_gap(recv_burst);
         if (k > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (k) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      draw_cmd_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         cmds_seen++;
         if (pending_cmds.size() == 0) begin
            $error("draw command beat with nothing pending");
            fail_count++;
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_ch.src_left !== want.src_left) begin
               $error("src_left exp %0d got %0d", want.src_left, rsp_ch.src_left);
               fail_count++;
            end
            if (rsp_ch.src_top !== want.src_top) begin
               $error("src_top exp %0d got %0d", want.src_top, rsp_ch.src_top);
               fail_count++;
            end
            if (rsp_ch.src_right !== want.src_right) begin
               $error("src_right exp %0d got %0d", want.src_right, rsp_ch.src_right);
               fail_count++;
            end
            if (rsp_ch.src_bottom !== want.src_bottom) begin
               $error("src_bottom exp %0d got %0d", want.src_bottom, rsp_ch.src_bottom);
               fail_count++;
            end
            if (rsp_ch.dst_left !== want.dst_left) begin
               $error("dst_left exp %0d got %0d", want.dst_left, rsp_ch.dst_left);
               fail_count++;
            end
            if (rsp_ch.dst_top !== want.dst_top) begin
               $error("dst_top exp %0d got %0d", want.dst_top, rsp_ch.dst_top);
               fail_count++;
            end
            if (rsp_ch.dst_right !== want.dst_right) begin
               $error("dst_right exp %0d got %0d", want.dst_right, rsp_ch.dst_right);
               fail_count++;
            end
            if (rsp_ch.dst_bottom !== want.dst_bottom) begin
               $error("dst_bottom exp %0d got %0d", want.dst_bottom, rsp_ch.dst_bottom);
               fail_count++;
            end
            if (rsp_ch.depth !== want.depth) begin
               $error("depth exp %0d got %0d", want.depth, rsp_ch.depth);
               fail_count++;
            end
            if (rsp_ch.out_material !== want.material) begin
               $error("out_material exp %0d got %0d", want.material, rsp_ch.out_material);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [31:0] cams[2*N_PHASE];
      logic [31:0] views[N_PHASE][6];
      sprite_type sp;
      reset = 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.sprite_pos_x <= '0;
      req_ch.sprite_pos_y <= '0;
      req_ch.tex_org_x <= '0;
      req_ch.tex_org_y <= '0;
      req_ch.tex_size_w <= '0;
      req_ch.tex_size_h <= '0;
      req_ch.material_id <= '0;
      scr_w = bsp_pkg::RST_SCREEN_W;
      scr_h = bsp_pkg::RST_SCREEN_H;
      cam_x = 0;
      cam_y = 0;
      fac_x = bsp_pkg::ONE;
      fac_y = 0;
      foreach (cams[i]) cams[i] = $urandom;

      // reset view: 320x240, camera at origin looking along +x
      dir_rows[0]  = dir_row(CHK_TYPED, 32'h0001_0000, 0, 0, 0, 16, 16, 7);
      dir_rows[0].cmd = '{16'd0, 16'd0, 17'd16, 17'd16, 18'sd40, 18'sd0, 18'sd280,
                          18'sd240, 31'd65536, 16'd7};
      dir_rows[1]  = dir_row(CHK_NONE, 32'hFFFF_0000, 0, 1, 2, 3, 4, 5);    // behind
      dir_rows[2]  = dir_row(CHK_NONE, 0, 0, 1, 2, 3, 4, 5);                // at camera
      dir_rows[3]  = dir_row(CHK_NONE, 32'h0001_0000, 0, 9, 9, 9, 0, 9);    // empty texture
      dir_rows[4]  = dir_row(CHK_NONE, 32'h0001_0000, 32'h0002_0000, 0, 0, 8, 8, 1);
      dir_rows[5]  = dir_row(CHK_MODEL, 1, 0, 3, 3, 8, 8, 2);               // nearest depth
      dir_rows[6]  = dir_row(CHK_MODEL, 32'h7FFF_FFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF);
      dir_rows[7]  = dir_row(CHK_MODEL, 32'h0001_0000, 32'h0001_8000, 0, 0, 4, 4, 3);
      dir_rows[8]  = dir_row(CHK_NONE, 32'h0001_0000, 32'h0001_8001, 0, 0, 4, 4, 3);
      dir_rows[9]  = dir_row(CHK_MODEL, 32'h8000_0000, 32'h8000_0000, 1, 1, 1, 1, 1);
      dir_rows[10] = dir_row(CHK_MODEL, 32'h000A_0000, 32'hFFFB_0000, 0, 0, 1, 1, 0);
      dir_rows[11] = dir_row(CHK_MODEL, 32'h0003_0000, 32'hFFFF_8000, 5, 6, 0, 9, 4);
      dir_rows[12] = dir_row(CHK_MODEL, 32'h0003_0000, 32'h0001_0000, 16'hFFFF, 0,
                             16'hFFFF, 1, 16'h8000);

      views[0] = '{320, 240, 0, 0, 32'h0001_0000, 0};
      views[1] = '{1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h0001_0000};
      views[2] = '{4096, 4096, 32'h00BC_614E, 32'hFFF0_EDFA, 32'h0003_0000, 0};
      views[3] = '{8191, 8191, cams[6], cams[7], 46341, 32'h0003_4AFB};
      views[4] = '{0, 0, cams[8], cams[9], 0, 32'h0003_0000};
      views[5] = '{640, 480, cams[10], cams[11], 32'h0003_4AFB, 46341};
      views[6] = '{1920, 1080, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIR; i++) send_sprite(dir_rows[i].sp, dir_rows[i].kind,
                                                  dir_rows[i].cmd);
      drain();

      for (int ph = 0; ph < N_PHASE; ph++) begin
         set_view(views[ph][0], views[ph][1], views[ph][2], views[ph][3], views[ph][4],
                  views[ph][5]);
         if (ph == 2) write_csr(UNMAPPED_ADDR, $urandom);
         // far corner from a camera at the most negative corner overflows depth
         if (ph == N_PHASE - 1) begin
            sp = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1, 1, 16'h00AA};
            send_sprite(sp, CHK_MODEL, '0);
         end
         for (int n = 0; n < PER_PHASE; n++) send_sprite(random_sprite(), CHK_MODEL, '0);
         drain();
      end

      $display("sent %0d sprites over %0d views, %0d draw commands checked",
               sprites_sent, N_PHASE + 1, cmds_seen);
      $display("covered culling, lateral limits, depth and size saturation, screen extremes");
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
